[design/ogrm_pkg.sv]
`default_nettype none

package ogrm_pkg;

   localparam int DEF_MAX_COLUMNS = 256;
   localparam int DEF_MAX_ROWS    = 256;

   localparam int COORD_W = 16;
   localparam int DIM_W   = 9;
   localparam int LIM_W   = 16;

   localparam logic [DIM_W-1:0] GRID_DIM_RESET = 9'd200;

   localparam logic CSR_GRID_WIDTH  = 1'b0;
   localparam logic CSR_GRID_HEIGHT = 1'b1;

   localparam logic OP_TRACE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   localparam logic [1:0] CELL_UNKNOWN  = 2'd0;
   localparam logic [1:0] CELL_FREE     = 2'd1;
   localparam logic [1:0] CELL_OCCUPIED = 2'd2;

   localparam logic [1:0] KIND_CLEAR = 2'd0;
   localparam logic [1:0] KIND_TRACE = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

   typedef struct packed {
      logic                      operation;
      logic signed [COORD_W-1:0] start_x;
      logic signed [COORD_W-1:0] start_y;
      logic signed [COORD_W-1:0] end_x;
      logic signed [COORD_W-1:0] end_y;
   } req_type;

   typedef struct packed {
      logic [1:0] cell_state;
      logic       in_grid;
   } rsp_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] kind;
      logic       on_grid;
      logic       last;
   } acc_type;

endpackage

`default_nettype wire

[design/ogrm_cell_ram.sv]
`default_nettype none

module ogrm_cell_ram #(
   parameter int ADDR_W = 16,
   parameter int DATA_W = 2
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

[design/ogrm_ray_walker.sv]
`default_nettype none

module ogrm_ray_walker #(
   parameter int MAX_COLUMNS = ogrm_pkg::DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = ogrm_pkg::DEF_MAX_ROWS,
   parameter int ADDR_W      = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire ogrm_pkg::req_type       req_data,
   input  wire logic                    rd_block,
   input  wire logic [ogrm_pkg::DIM_W-1:0] grid_width,
   input  wire logic [ogrm_pkg::DIM_W-1:0] grid_height,
   output ogrm_pkg::acc_type            acc,
   output logic      [ADDR_W-1:0]       acc_addr
);

   import ogrm_pkg::*;

   localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_COLUMNS * MAX_ROWS - 1);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_WALK  = 2'd2;

   logic [1:0]                state_ff, state_in;
   logic [ADDR_W-1:0]         clear_addr_ff, clear_addr_in;
   logic signed [COORD_W-1:0] wx_ff, wx_in, wy_ff, wy_in;
   logic signed [COORD_W-1:0] ex_ff, ex_in, ey_ff, ey_in;
   logic signed [17:0]        err_ff, err_in;
   logic signed [16:0]        dx_ff, dx_in, dy_ff, dy_in;
   logic                      sx_neg_ff, sx_neg_in, sy_neg_ff, sy_neg_in;

   logic [LIM_W-1:0]          lim_w, lim_h;
   logic                      accept;
   logic signed [16:0]        x0e, y0e, x1e, y1e, dx_new, dy_new;
   logic signed [18:0]        e2, dxx, dyx, err_sum;
   logic                      step_x, step_y, at_end;

   function automatic logic in_grid_f(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                      input logic [LIM_W-1:0] w, input logic [LIM_W-1:0] h);
      return !x[COORD_W-1] && !y[COORD_W-1] && (LIM_W'(x) < w) && (LIM_W'(y) < h);
   endfunction

   function automatic logic [ADDR_W-1:0] cell_addr_f(input logic [COORD_W-1:0] x,
                                                     input logic [COORD_W-1:0] y);
      return ADDR_W'(y[ROW_W-1:0]) * ADDR_W'(MAX_COLUMNS) + ADDR_W'(x[COL_W-1:0]);
   endfunction

   assign lim_w = (LIM_W'(grid_width) > LIM_W'(MAX_COLUMNS)) ? LIM_W'(MAX_COLUMNS)
                                                              : LIM_W'(grid_width);
   assign lim_h = (LIM_W'(grid_height) > LIM_W'(MAX_ROWS)) ? LIM_W'(MAX_ROWS)
                                                            : LIM_W'(grid_height);

   assign req_stall = (state_ff != ST_IDLE) || ((req_data.operation == OP_READ) && rd_block);
   assign accept    = req_valid && !req_stall;

   assign x0e = {req_data.start_x[COORD_W-1], req_data.start_x};
   assign y0e = {req_data.start_y[COORD_W-1], req_data.start_y};
   assign x1e = {req_data.end_x[COORD_W-1], req_data.end_x};
   assign y1e = {req_data.end_y[COORD_W-1], req_data.end_y};
   assign dx_new = (x1e > x0e) ? (x1e - x0e) : (x0e - x1e);
   assign dy_new = (y1e > y0e) ? (y0e - y1e) : (y1e - y0e);

   assign e2      = {err_ff, 1'b0};
   assign dxx     = {{2{dx_ff[16]}}, dx_ff};
   assign dyx     = {{2{dy_ff[16]}}, dy_ff};
   assign step_x  = (e2 >= dyx);
   assign step_y  = (e2 <= dxx);
   assign err_sum = {err_ff[17], err_ff} + (step_x ? dyx : 19'sd0) + (step_y ? dxx : 19'sd0);
   assign at_end  = (wx_ff == ex_ff) && (wy_ff == ey_ff);

   always_comb begin
      state_in      = state_ff;
      clear_addr_in = clear_addr_ff;
      wx_in         = wx_ff;
      wy_in         = wy_ff;
      ex_in         = ex_ff;
      ey_in         = ey_ff;
      err_in        = err_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      sx_neg_in     = sx_neg_ff;
      sy_neg_in     = sy_neg_ff;
      acc           = '0;
      acc_addr      = cell_addr_f(wx_ff, wy_ff);
      unique case (state_ff)
         ST_CLEAR: begin
            acc.valid     = 1'b1;
            acc.kind      = KIND_CLEAR;
            acc.on_grid   = 1'b1;
            acc_addr      = clear_addr_ff;
            clear_addr_in = clear_addr_ff + ADDR_W'(1);
            if (clear_addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept && (req_data.operation == OP_READ)) begin
               acc.valid   = 1'b1;
               acc.kind    = KIND_READ;
               acc.on_grid = in_grid_f(req_data.start_x, req_data.start_y, lim_w, lim_h);
               acc_addr    = cell_addr_f(req_data.start_x, req_data.start_y);
            end else if (accept) begin
               wx_in     = req_data.start_x;
               wy_in     = req_data.start_y;
               ex_in     = req_data.end_x;
               ey_in     = req_data.end_y;
               dx_in     = dx_new;
               dy_in     = dy_new;
               err_in    = {dx_new[16], dx_new} + {dy_new[16], dy_new};
               sx_neg_in = !(x0e < x1e);
               sy_neg_in = !(y0e < y1e);
               state_in  = ST_WALK;
            end
         end
         ST_WALK: begin
            acc.valid   = 1'b1;
            acc.kind    = KIND_TRACE;
            acc.on_grid = in_grid_f(wx_ff, wy_ff, lim_w, lim_h);
            acc.last    = at_end;
            if (at_end) begin
               state_in = ST_IDLE;
            end else begin
               err_in = err_sum[17:0];
               if (step_x) begin
                  wx_in = wx_ff + (sx_neg_ff ? 16'shFFFF : 16'sh0001);
               end
               if (step_y) begin
                  wy_in = wy_ff + (sy_neg_ff ? 16'shFFFF : 16'sh0001);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
         wx_ff         <= '0;
         wy_ff         <= '0;
         err_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         wx_ff         <= wx_in;
         wy_ff         <= wy_in;
         err_ff        <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      ex_ff     <= ex_in;
      ey_ff     <= ey_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      sx_neg_ff <= sx_neg_in;
      sy_neg_ff <= sy_neg_in;
   end

endmodule

`default_nettype wire

[design/occupancy_grid_ray_marker.sv]
`default_nettype none

// Occupancy grid of 2-bit cells (unknown, free, occupied) in one on-chip RAM of
// MAX_COLUMNS * MAX_ROWS entries. After reset the block sweeps the RAM to unknown,
// one cell per cycle, so req_stall stays high until all MAX_COLUMNS * MAX_ROWS
// cells (65536 at the defaults) are swept; configuration writes are taken during
// the sweep. A trace beat first loads the line, then does one read-modify-write
// of the cell RAM per visited cell, and req_stall stays high until the walk
// reaches its end cell. A read result passes the RAM read register and then the
// output register; a new read waits until the previous result has left the
// output register and no read is in flight, while a trace may start at once.
module occupancy_grid_ray_marker #(
   parameter int MAX_COLUMNS = ogrm_pkg::DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = ogrm_pkg::DEF_MAX_ROWS
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire ogrm_pkg::req_type          req_data,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output ogrm_pkg::rsp_type               rsp_data,
   input  wire logic                       csr_wen,
   input  wire logic                       csr_index,
   input  wire logic [ogrm_pkg::DIM_W-1:0] csr_wdata
);

   import ogrm_pkg::*;

   localparam int ADDR_W = $clog2(MAX_COLUMNS * MAX_ROWS);

   logic [DIM_W-1:0]  grid_width_ff, grid_width_in, grid_height_ff, grid_height_in;
   acc_type           acc, b_acc_ff;
   logic [ADDR_W-1:0] acc_addr, b_addr_ff;
   logic [1:0]        ram_rd_data, cur_state, wr_data;
   logic              wr_en, b_read, rd_block;
   logic              fwd_hit_ff, fwd_hit_in;
   logic [1:0]        fwd_data_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      if (csr_wen) begin
         unique case (csr_index)
            CSR_GRID_WIDTH:  grid_width_in  = csr_wdata;
            CSR_GRID_HEIGHT: grid_height_in = csr_wdata;
            default:         grid_width_in  = grid_width_ff;
         endcase
      end
   end

   assign b_read   = b_acc_ff.valid && (b_acc_ff.kind == KIND_READ);
   assign rd_block = rsp_valid_ff || b_read;

   ogrm_ray_walker #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS),
      .ADDR_W      (ADDR_W)
   ) u_walker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rd_block    (rd_block),
      .grid_width  (grid_width_ff),
      .grid_height (grid_height_ff),
      .acc         (acc),
      .acc_addr    (acc_addr)
   );

   ogrm_cell_ram #(
      .ADDR_W (ADDR_W),
      .DATA_W (2)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (b_addr_ff),
      .wr_data (wr_data),
      .rd_addr (acc_addr),
      .rd_data (ram_rd_data)
   );

   assign cur_state = fwd_hit_ff ? fwd_data_ff : ram_rd_data;

   always_comb begin
      wr_en   = 1'b0;
      wr_data = CELL_UNKNOWN;
      if (b_acc_ff.valid && (b_acc_ff.kind == KIND_CLEAR)) begin
         wr_en = 1'b1;
      end else if (b_acc_ff.valid && (b_acc_ff.kind == KIND_TRACE) && b_acc_ff.on_grid) begin
         wr_en   = 1'b1;
         wr_data = (b_acc_ff.last || (cur_state == CELL_OCCUPIED)) ? CELL_OCCUPIED : CELL_FREE;
      end
   end

   // forward a write that lands in the cycle its cell is read
   assign fwd_hit_in = wr_en && (b_addr_ff == acc_addr);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (b_read) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.in_grid    = b_acc_ff.on_grid;
         rsp_data_in.cell_state = b_acc_ff.on_grid ? cur_state : CELL_UNKNOWN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= GRID_DIM_RESET;
         grid_height_ff <= GRID_DIM_RESET;
         b_acc_ff       <= '0;
         fwd_hit_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
         b_acc_ff       <= acc;
         fwd_hit_ff     <= fwd_hit_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      b_addr_ff   <= acc_addr;
      fwd_data_ff <= wr_data;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      b_read |-> !rsp_valid_ff)
      else $error("read result arrives while output register is full");

   a_walk_continues: assert property (@(posedge clock) disable iff (reset)
      (b_acc_ff.valid && (b_acc_ff.kind == KIND_TRACE) && !b_acc_ff.last)
      |=> (b_acc_ff.valid && (b_acc_ff.kind == KIND_TRACE)))
      else $error("ray walk ended before reaching its end cell");

   a_occupied_kept: assert property (@(posedge clock) disable iff (reset)
      (wr_en && (b_acc_ff.kind == KIND_TRACE) && (cur_state == CELL_OCCUPIED))
      |-> (wr_data == CELL_OCCUPIED))
      else $error("occupied cell cleared by a ray");

   a_stall_during_walk: assert property (@(posedge clock) disable iff (reset)
      (acc.valid && (acc.kind == KIND_TRACE)) |-> req_stall)
      else $error("beat accepted during a ray walk");

endmodule

`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 100ps

module testbench;
   import ogrm_pkg::*;

   localparam int CELL_COUNT = DEF_MAX_COLUMNS * DEF_MAX_ROWS;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_type          req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_type          rsp_data;
   logic             csr_wen   = 1'b0;
   logic             csr_index = CSR_GRID_WIDTH;
   logic [DIM_W-1:0] csr_wdata = '0;

   logic [1:0] cell_map [0:CELL_COUNT-1];
   int         grid_cols;
   int         grid_rows;
   rsp_type    pending_reads[$];
   int         mismatches = 0;
   int         last_span  = 0;
   bit         steady     = 1'b0;

   occupancy_grid_ray_marker dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(99) < 34);
   end

   always @(posedge clock) begin : check_reads
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_reads.size() == 0) begin
            $display("%0t: unexpected read beat: expected none, actual state %0d in_grid %0d",
                     $time, rsp_data.cell_state, rsp_data.in_grid);
            mismatches++;
         end else begin
            want = pending_reads.pop_front();
            if (rsp_data.cell_state !== want.cell_state) begin
               $display("%0t: cell_state expected %0d actual %0d",
                        $time, want.cell_state, rsp_data.cell_state);
               mismatches++;
            end
            if (rsp_data.in_grid !== want.in_grid) begin
               $display("%0t: in_grid expected %0d actual %0d",
                        $time, want.in_grid, rsp_data.in_grid);
               mismatches++;
            end
         end
      end
   end

   function automatic bit on_map(int x, int y);
      int w;
      int h;
      w = grid_cols > DEF_MAX_COLUMNS ? DEF_MAX_COLUMNS : grid_cols;
      h = grid_rows > DEF_MAX_ROWS ? DEF_MAX_ROWS : grid_rows;
      return x >= 0 && x < w && y >= 0 && y < h;
   endfunction

   function automatic void trace_ray(int x0, int y0, int x1, int y1);
      int dx;
      int dy;
      int sx;
      int sy;
      int cx;
      int cy;
      int err;
      int e2;
      int a;
      dx  = x1 > x0 ? x1 - x0 : x0 - x1;
      dy  = y1 > y0 ? y0 - y1 : y1 - y0;
      sx  = x0 < x1 ? 1 : -1;
      sy  = y0 < y1 ? 1 : -1;
      cx  = x0;
      cy  = y0;
      err = dx + dy;
      while (1) begin
         if (on_map(cx, cy)) begin
            a = cy * DEF_MAX_COLUMNS + cx;
            if (cell_map[a] != CELL_OCCUPIED)
               cell_map[a] = CELL_FREE;
         end
         if (cx == x1 && cy == y1)
            break;
         e2 = 2 * err;
         if (e2 >= dy) begin
            err += dy;
            cx  += sx;
         end
         if (e2 <= dx) begin
            err += dx;
            cy  += sy;
         end
      end
      if (on_map(x1, y1))
         cell_map[y1 * DEF_MAX_COLUMNS + x1] = CELL_OCCUPIED;
      last_span = (dx > -dy ? dx : -dy) + 2;
   endfunction

   function automatic void predict_beat(req_type beat);
      rsp_type r;
      int      x;
      int      y;
      x = $signed(beat.start_x);
      y = $signed(beat.start_y);
      if (beat.operation == OP_TRACE) begin
         trace_ray(x, y, $signed(beat.end_x), $signed(beat.end_y));
      end else begin
         r.in_grid    = on_map(x, y);
         r.cell_state = r.in_grid ? cell_map[y * DEF_MAX_COLUMNS + x] : CELL_UNKNOWN;
         pending_reads.push_back(r);
         last_span = 0;
      end
   endfunction

   function automatic req_type make_beat(logic op, int x0, int y0, int x1, int y1);
      req_type b;
      b.operation = op;
      b.start_x   = 16'(x0);
      b.start_y   = 16'(y0);
      b.end_x     = 16'(x1);
      b.end_y     = 16'(y1);
      return b;
   endfunction

   function automatic int near_coord();
      return int'($urandom_range(320)) - 30;
   endfunction

   function automatic int any_coord();
      return int'($urandom_range(65535)) - 32768;
   endfunction

   function automatic int nudge_coord(int v);
      int n;
      n = v + int'($urandom_range(80)) - 40;
      if (n > 32767)
         n = 32767;
      if (n < -32768)
         n = -32768;
      return n;
   endfunction

   function automatic req_type random_beat();
      int pick;
      int x0;
      int y0;
      pick = $urandom_range(99);
      if (pick < 45) begin
         if ($urandom_range(99) < 85)
            return make_beat(OP_READ, near_coord(), near_coord(), any_coord(), any_coord());
         return make_beat(OP_READ, any_coord(), any_coord(), any_coord(), any_coord());
      end
      if (pick < 80)
         return make_beat(OP_TRACE, near_coord(), near_coord(), near_coord(), near_coord());
      x0 = any_coord();
      y0 = any_coord();
      return make_beat(OP_TRACE, x0, y0, nudge_coord(x0), nudge_coord(y0));
   endfunction

   task automatic send_beat(req_type beat);
      while (!steady && $urandom_range(99) < 34) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (req_stall);
      predict_beat(beat);
   endtask

   task automatic send_read(int x, int y);
      send_beat(make_beat(OP_READ, x, y, 0, 0));
   endtask

   task automatic send_trace(int x0, int y0, int x1, int y1);
      send_beat(make_beat(OP_TRACE, x0, y0, x1, y1));
   endtask

   task automatic write_reg(logic idx, logic [DIM_W-1:0] value);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      if (idx == CSR_GRID_WIDTH)
         grid_cols = value;
      else
         grid_rows = value;
      @(posedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pending_reads.size() != 0)
         @(posedge clock);
      repeat (last_span + 8) @(posedge clock);
   endtask

   task automatic set_grid(int w, int h);
      settle();
      write_reg(CSR_GRID_WIDTH, DIM_W'(w));
      write_reg(CSR_GRID_HEIGHT, DIM_W'(h));
   endtask

   task automatic run_random(int count);
      repeat (count) send_beat(random_beat());
   endtask

   task automatic test_basic_marking();
      send_read(0, 0);
      send_read(199, 199);
      send_trace(0, 0, 10, 5);
      send_read(0, 0);
      send_read(10, 5);
      send_read(5, 2);
      send_trace(3, 3, 3, 3);
      send_read(3, 3);
      send_trace(10, 5, 20, 5);
      send_read(10, 5);
      send_read(15, 5);
      send_trace(-5, -5, 5, 5);
      send_read(0, 0);
      send_read(3, 3);
      send_trace(100, 100, 250, 150);
      send_read(199, 133);
      send_trace(20, 30, 12, 2);
      send_read(12, 2);
      send_read(200, 0);
      send_read(0, 200);
      send_read(-1, 0);
      send_read(0, -1);
      send_read(-32768, 32767);
   endtask

   task automatic test_full_span_rays();
      send_trace(-32768, -32768, 32767, 32767);
      send_read(7, 7);
      send_trace(32767, 32767, -32768, -32767);
      send_read(50, 50);
   endtask

   task automatic test_dimension_limits();
      set_grid(511, 511);
      send_read(255, 255);
      send_read(256, 0);
      send_read(0, 256);
      send_trace(250, 250, 300, 255);
      send_read(255, 255);
      set_grid(0, 0);
      send_read(0, 0);
      send_trace(0, 0, 5, 5);
      send_read(5, 5);
      set_grid(1, 1);
      send_read(0, 0);
      send_read(1, 0);
      send_read(0, 1);
      send_trace(-3, 0, 2, 0);
      send_read(0, 0);
   endtask

   task automatic test_random_maps();
      set_grid(200, 200);
      run_random(150);
      set_grid(256, 256);
      steady = 1'b1;
      run_random(150);
      steady = 1'b0;
      set_grid(511, 300);
      run_random(100);
      set_grid(0, 0);
      run_random(60);
      set_grid(1, 256);
      run_random(60);
      set_grid(37, 250);
      run_random(120);
      set_grid(200, 200);
      run_random(110);
   endtask

   initial begin
      foreach (cell_map[i])
         cell_map[i] = CELL_UNKNOWN;
      grid_cols = GRID_DIM_RESET;
      grid_rows = GRID_DIM_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_basic_marking();
      test_full_span_rays();
      test_dimension_limits();
      test_random_maps();
      settle();
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #60_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
